// ----- rtl/srdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Share-rate retarget package
// Shared types and constants for the share-rate difficulty retarget unit.
// ----------------------------------------------------------------------------
package srdr_pkg;

    localparam int DW     = 64;             // internal arithmetic width
    localparam int CFG_W  = 48;             // configuration register width
    localparam int ADDR_W = 5;              // three 64-bit registers at 8*i

    localparam logic [DW-1:0] ONES    = {DW{1'b1}};
    localparam logic [32:0]   ONE_Q32 = 33'h1_0000_0000;

    // rate windows and their clamped arguments (36 windows)
    localparam logic [18:0] FAST_WIN = 19'd60000;
    localparam logic [18:0] SLOW_WIN = 19'd300000;
    localparam logic [23:0] FAST_LIM = 24'd2160000;
    localparam logic [23:0] SLOW_LIM = 24'd10800000;

    localparam logic [17:0] CHECK_MS     = 18'd240000;
    localparam logic [6:0]  CHECK_SHARES = 7'd72;
    localparam logic [6:0]  CNT_MAX      = 7'd127;
    localparam logic [31:0] DRR_LOW      = 32'd644245094;
    localparam logic [31:0] DRR_HIGH     = 32'd1717986918;

    localparam logic [8:0]  RATE_MUL  = 9'd333;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam logic [6:0]  RATE_DIV  = 7'd100;

    localparam logic [5:0] FB_INT = 6'd0;
    localparam logic [5:0] FB_DRR = 6'd12;
    localparam logic [5:0] FB_Q20 = 6'd20;
    localparam logic [5:0] FB_Q32 = 6'd32;

    typedef enum logic [1:0] {
        REG_MIN  = 2'd0,
        REG_MAX  = 2'd1,
        REG_INIT = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        ST_FIRST     = 3'd0,
        ST_THROTTLED = 3'd1,
        ST_STALE     = 3'd2,
        ST_IN_BAND   = 3'd3,
        ST_BELOW_ONE = 3'd4,
        ST_SAME      = 3'd5,
        ST_IDLE_HOLD = 3'd6,
        ST_RETARGET  = 3'd7
    } t_status;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CTX_FAST = 2'd0,
        CTX_SLOW = 2'd1,
        CTX_BIAS = 2'd2
    } t_ctx;

    typedef enum logic [23:0] {
        S_IDLE  = 24'h000001,
        S_START = 24'h000002,
        S_WX    = 24'h000004,
        S_TINIT = 24'h000008,
        S_TMUL  = 24'h000010,
        S_TDIV  = 24'h000020,
        S_TACC  = 24'h000040,
        S_SQ    = 24'h000080,
        S_SQE   = 24'h000100,
        S_RMUL  = 24'h000200,
        S_RDIV  = 24'h000400,
        S_AMUL  = 24'h000800,
        S_ADIV  = 24'h001000,
        S_AEND  = 24'h002000,
        S_JUDGE = 24'h004000,
        S_DSPS  = 24'h008000,
        S_DRR   = 24'h010000,
        S_BAND  = 24'h020000,
        S_PDIV1 = 24'h040000,
        S_PMUL2 = 24'h080000,
        S_PDIV2 = 24'h100000,
        S_CLAMP = 24'h200000,
        S_PUSH  = 24'h400000,
        S_WAIT  = 24'h800000
    } t_state;

    typedef struct packed {
        logic          start;
        t_op           op;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [5:0]    fb;
    } t_op_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] q;
        logic [DW-1:0] r;
    } t_op_rsp;

endpackage

// ----- rtl/srdr_share_if.sv -----
// ----------------------------------------------------------------------------
// Share channel
// Valid/ready channel carrying one submitted share per word.
// ----------------------------------------------------------------------------
interface srdr_share_if #(
    parameter int TIME_BITS = 48,
    parameter int DIFF_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] share_time_ms;
    logic [DIFF_BITS-1:0] share_difficulty;
    logic [DIFF_BITS-1:0] network_difficulty;

    modport source (output valid, share_time_ms, share_difficulty, network_difficulty,
                    input ready);
    modport sink   (input valid, share_time_ms, share_difficulty, network_difficulty,
                    output ready);
endinterface

// ----- rtl/srdr_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one retarget verdict per word.
// ----------------------------------------------------------------------------
interface srdr_result_if #(
    parameter int DIFF_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic                 changed;
    logic [DIFF_BITS-1:0] difficulty;
    logic [2:0]           status;

    modport source (output valid, changed, difficulty, status, input ready);
    modport sink   (input valid, changed, difficulty, status, output ready);
endinterface

// ----- rtl/srdr_serial_unit.sv -----
// ----------------------------------------------------------------------------
// Bit-serial multiply / divide unit
// Shift-add multiply (64 x 33, one multiplier bit a cycle) and restoring
// fractional divide floor(a*2^fb/b), one quotient bit a cycle, saturating.
// ----------------------------------------------------------------------------
module srdr_serial_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srdr_pkg::t_op_req i_req,
    output srdr_pkg::t_op_rsp o_rsp
);
    import srdr_pkg::*;

    logic          r_busy;
    logic          r_done;
    t_op           r_op;
    logic [6:0]    r_cnt;
    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_q;
    logic          r_ovf;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW-1:0] rem_nx;
    logic [DW:0]   add;
    logic          den_zero;

    always_comb begin
        rem_sh   = {r_acc, r_a[DW-1]};
        ge       = rem_sh >= {1'b0, r_b};
        rem_nx   = ge ? DW'(rem_sh - {1'b0, r_b}) : rem_sh[DW-1:0];
        add      = {1'b0, r_acc} + (r_b[0] ? {1'b0, r_a} : {(DW+1){1'b0}});
        den_zero = (i_req.op == OP_DIV) && (i_req.b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= !den_zero;
                r_done <= den_zero;
            end else if (r_busy && r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_a   <= i_req.a;
            r_b   <= (i_req.op == OP_MUL) ? {31'd0, i_req.b[32:0]} : i_req.b;
            r_acc <= '0;
            r_q   <= den_zero ? ONES : '0;
            r_ovf <= 1'b0;
            r_cnt <= (i_req.op == OP_MUL) ? 7'd33 : 7'(DW) + 7'(i_req.fb);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_op == OP_DIV) begin
                r_a   <= {r_a[DW-2:0], 1'b0};
                r_acc <= rem_nx;
                r_q   <= {r_q[DW-2:0], ge};
                r_ovf <= r_ovf | r_q[DW-1];
            end else begin
                r_acc <= add[DW:1];
                r_q   <= {31'd0, add[0], r_q[32:1]};
                r_b   <= {1'b0, r_b[DW-1:1]};
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_op == OP_DIV) begin
            o_rsp.q = r_ovf ? ONES : r_q;
            o_rsp.r = r_acc;
        end else begin
            // product bit 96 set means the Q32 result overflows
            o_rsp.q = r_acc[DW-1] ? ONES : {r_acc[DW-2:0], r_q[32]};
            o_rsp.r = {r_acc[30:0], r_q[32:0]};
        end
    end

endmodule

// ----- rtl/share_rate_difficulty_retarget_unit.sv -----
// ----------------------------------------------------------------------------
// Share-rate difficulty retarget unit
// Tracks decaying share-rate averages and proposes a new miner difficulty.
// ----------------------------------------------------------------------------
// Usage: one share word enters on i_share (valid/ready); exactly one verdict
// word leaves on o_result (changed, difficulty, status). The APB port holds
// the minimum, maximum and initial difficulty at byte addresses 0, 8 and 16;
// a write to one of these three restarts the session and reloads the
// current difficulty. The first share of a session only seeds the timestamps.
// Every later share runs two rate-average updates (each a weight evaluation
// of one 96-step divide, twelve Taylor multiply/divide pairs and six
// squarings, then two 33-step multiplies and two divides) before a throttled
// or stale verdict; a judged share adds a third weight plus the rate, ratio
// and proposal arithmetic. All of it runs through the one bit-serial
// multiply/divide unit.
// Throughput: one share at a time; i_share.ready is high only while idle.
// Reset: limits return to 1 / none / 1 and the session restarts.
// Stall: a finished verdict waits in the output register; the next share is
// taken meanwhile and its verdict is held back until that register empties.
// ----------------------------------------------------------------------------
module share_rate_difficulty_retarget_unit #(
    parameter int TIME_BITS = 48,
    parameter int DIFF_BITS = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    srdr_share_if.sink                  i_share,
    srdr_result_if.source               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srdr_pkg::ADDR_W-1:0] paddr,
    input  logic [srdr_pkg::DW-1:0]     pwdata,
    output logic [srdr_pkg::DW-1:0]     prdata,
    output logic                        pready
);
    import srdr_pkg::*;

    localparam logic [DW-1:0] DIFF_MAX =
        (DIFF_BITS == DW) ? ONES : ((64'd1 << DIFF_BITS) - 64'd1);

    // gap between two times in ms, floored at one (also when now is earlier)
    function automatic logic [TIME_BITS-1:0] gap(input logic [TIME_BITS-1:0] a,
                                                 input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = (a >= b) ? a - b : '0;
        return (d == '0) ? TIME_BITS'(1) : d;
    endfunction

    // initial difficulty clamped: minimum first, then maximum
    function automatic logic [DIFF_BITS-1:0] clamp_init(input logic [CFG_W-1:0] mn,
                                                        input logic [CFG_W-1:0] mx,
                                                        input logic [CFG_W-1:0] ini);
        logic [CFG_W-1:0] c;
        c = ini;
        if (c < mn) c = mn;
        if (mx != '0 && c > mx) c = mx;
        return DIFF_BITS'(64'(c));
    endfunction

    // ---- state --------------------------------------------------------------
    t_state               r_state, n_state, r_ret, n_ret;
    t_ctx                 r_ctx, n_ctx;
    logic                 r_fast, n_fast;
    t_status              r_status, n_status;

    logic [CFG_W-1:0]     r_min, n_min, r_max, n_max, r_init, n_init;

    logic                 r_started, n_started;
    logic [TIME_BITS-1:0] r_first, n_first, r_last, n_last, r_change, n_change;
    logic [6:0]           r_cnt, n_cnt;
    logic [DW-1:0]        r_favg, n_favg, r_savg, n_savg;
    logic [DIFF_BITS-1:0] r_cur, n_cur;

    logic                 r_o_valid, n_o_valid;
    logic                 r_o_changed, n_o_changed;
    logic [DIFF_BITS-1:0] r_o_diff, n_o_diff;
    t_status              r_o_status, n_o_status;

    // working registers of the share in flight
    logic [TIME_BITS-1:0] r_now, n_now, r_dt, n_dt, r_arg, n_arg;
    logic [DIFF_BITS-1:0] r_sdiff, n_sdiff, r_ndiff, n_ndiff;
    logic [31:0]          r_y, n_y, r_p, n_p;
    logic [32:0]          r_term, n_term, r_w, n_w;
    logic signed [DW-1:0] r_s, n_s;
    logic [3:0]           r_k, n_k;
    logic [2:0]           r_sqc, n_sqc;
    logic [DW-1:0]        r_dsps, n_dsps, r_pq, n_pq, r_res_q, n_res_q, r_res_r, n_res_r;
    logic [6:0]           r_prem, n_prem;

    t_op_req              req;
    t_op_rsp              rsp;

    // ---- combinational helpers ---------------------------------------------
    logic                 cfg_we;
    logic                 win_fast;
    logic [TIME_BITS-1:0] lim, wx_d, since, age;
    logic [6:0]           cnt_inc;
    logic signed [DW-1:0] s_nx;
    logic [31:0]          p_clamp, p_sq;
    logic [DW-1:0]        avg_sel, avg_sum, opt, numer;

    srdr_serial_unit u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg'(paddr[4:3]))
            REG_MIN:  prdata = 64'(r_min);
            REG_MAX:  prdata = 64'(r_max);
            REG_INIT: prdata = 64'(r_init);
            default:  prdata = '0;
        endcase
    end

    assign i_share.ready       = (r_state == S_IDLE);
    assign o_result.valid      = r_o_valid;
    assign o_result.changed    = r_o_changed;
    assign o_result.difficulty = r_o_diff;
    assign o_result.status     = r_o_status;

    always_comb begin
        // defaults: hold everything
        n_state = r_state;   n_ret = r_ret;     n_ctx = r_ctx;     n_fast = r_fast;
        n_status = r_status; n_min = r_min;     n_max = r_max;     n_init = r_init;
        n_started = r_started; n_first = r_first; n_last = r_last; n_change = r_change;
        n_cnt = r_cnt;       n_favg = r_favg;   n_savg = r_savg;   n_cur = r_cur;
        n_o_valid = r_o_valid; n_o_changed = r_o_changed;
        n_o_diff = r_o_diff; n_o_status = r_o_status;
        n_now = r_now;       n_dt = r_dt;       n_arg = r_arg;
        n_sdiff = r_sdiff;   n_ndiff = r_ndiff;
        n_y = r_y;           n_p = r_p;         n_term = r_term;   n_w = r_w;
        n_s = r_s;           n_k = r_k;         n_sqc = r_sqc;
        n_dsps = r_dsps;     n_pq = r_pq;       n_prem = r_prem;
        n_res_q = r_res_q;   n_res_r = r_res_r;

        req       = '0;
        req.op    = OP_MUL;

        win_fast = (r_ctx == CTX_FAST) || ((r_ctx == CTX_BIAS) && r_fast);
        lim      = win_fast ? TIME_BITS'(FAST_LIM) : TIME_BITS'(SLOW_LIM);
        wx_d     = (r_arg < lim) ? r_arg : lim;
        cnt_inc  = (r_cnt == CNT_MAX) ? CNT_MAX : r_cnt + 7'd1;
        since    = gap(r_now, r_change);
        age      = gap(r_now, r_first);
        s_nx     = r_k[0] ? r_s - DW'(r_res_q[32:0]) : r_s + DW'(r_res_q[32:0]);
        p_clamp  = (s_nx < 0) ? 32'd0 :
                   (s_nx > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : s_nx[31:0];
        p_sq     = r_res_q[31:0];
        avg_sel  = (r_ctx == CTX_FAST) ? r_favg : r_savg;
        avg_sum  = (avg_sel > ONES - r_res_q) ? ONES : avg_sel + r_res_q;
        numer    = (64'(r_prem) << 20) + r_res_r + (64'd50 << 20);
        opt      = r_pq + r_res_q;
        if (opt > DIFF_MAX) opt = DIFF_MAX;
        if (opt < 64'(r_min)) opt = 64'(r_min);
        if (r_max != '0 && opt > 64'(r_max)) opt = 64'(r_max);
        if (r_ndiff != '0 && opt > 64'(r_ndiff)) opt = 64'(r_ndiff);

        // retire the word once the receiver has taken it
        if (r_o_valid && o_result.ready) n_o_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_share.valid) begin
                    n_now   = i_share.share_time_ms;
                    n_sdiff = i_share.share_difficulty;
                    n_ndiff = i_share.network_difficulty;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!r_started) begin
                    // first share only seeds the timestamps
                    n_started = 1'b1;
                    n_first   = r_now;
                    n_last    = r_now;
                    n_change  = r_now;
                    n_cnt     = 7'd1;
                    n_status  = ST_FIRST;
                    n_state   = S_PUSH;
                end else begin
                    n_dt    = gap(r_now, r_last);
                    n_arg   = gap(r_now, r_last);
                    n_last  = r_now;
                    n_ctx   = CTX_FAST;
                    n_state = S_WX;
                end
            end
            // weight: x = floor(min(d,36W)*2^32/W)
            S_WX: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = 64'(wx_d);
                req.b     = win_fast ? 64'(FAST_WIN) : 64'(SLOW_WIN);
                req.fb    = FB_Q32;
                n_ret     = S_TINIT;
                n_state   = S_WAIT;
            end
            S_TINIT: begin
                n_y     = r_res_q[37:6];
                n_term  = ONE_Q32;
                n_s     = DW'(ONE_Q32);
                n_k     = 4'd1;
                n_state = S_TMUL;
            end
            // Taylor term: floor(term*y/2^32)/k
            S_TMUL: begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.a     = 64'(r_y);
                req.b     = 64'(r_term);
                n_ret     = S_TDIV;
                n_state   = S_WAIT;
            end
            S_TDIV: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = r_res_q;
                req.b     = 64'(r_k);
                req.fb    = FB_INT;
                n_ret     = S_TACC;
                n_state   = S_WAIT;
            end
            S_TACC: begin
                n_term = r_res_q[32:0];
                n_s    = s_nx;
                if (r_k == 4'd12) begin
                    n_p     = p_clamp;
                    n_sqc   = 3'd0;
                    n_state = S_SQ;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_TMUL;
                end
            end
            // raise e^(-x/64) to the 64th power by six squarings
            S_SQ: begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.a     = 64'(r_p);
                req.b     = 64'(r_p);
                n_ret     = S_SQE;
                n_state   = S_WAIT;
            end
            S_SQE: begin
                n_p   = p_sq;
                n_sqc = r_sqc + 3'd1;
                if (r_sqc == 3'd5) begin
                    n_w     = ONE_Q32 - 33'(p_sq);
                    n_state = (r_ctx == CTX_BIAS) ? S_DSPS : S_RMUL;
                end else begin
                    n_state = S_SQ;
                end
            end
            // instantaneous rate: floor(diff*1000*2^20/dt)
            S_RMUL: begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.a     = 64'(r_sdiff);
                req.b     = 64'(MS_PER_S);
                n_ret     = S_RDIV;
                n_state   = S_WAIT;
            end
            S_RDIV: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = r_res_r;
                req.b     = 64'(r_dt);
                req.fb    = FB_Q20;
                n_ret     = S_AMUL;
                n_state   = S_WAIT;
            end
            S_AMUL: begin
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.a     = r_res_q;
                req.b     = 64'(r_w);
                n_ret     = S_ADIV;
                n_state   = S_WAIT;
            end
            // avg = sat(avg + r*w) / (1 + w)
            S_ADIV: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = avg_sum;
                req.b     = 64'(ONE_Q32) + 64'(r_w);
                req.fb    = FB_Q32;
                n_ret     = S_AEND;
                n_state   = S_WAIT;
            end
            S_AEND: begin
                if (r_ctx == CTX_FAST) begin
                    n_favg  = r_res_q;
                    n_ctx   = CTX_SLOW;
                    n_arg   = r_dt;
                    n_state = S_WX;
                end else begin
                    n_savg  = r_res_q;
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: begin
                n_cnt = cnt_inc;
                if (cnt_inc < CHECK_SHARES && since < TIME_BITS'(CHECK_MS)) begin
                    n_status = ST_THROTTLED;
                    n_state  = S_PUSH;
                end else if (r_sdiff != r_cur) begin
                    n_cnt    = 7'd0;
                    n_status = ST_STALE;
                    n_state  = S_PUSH;
                end else begin
                    // warm-up bias over the session age
                    n_fast  = (cnt_inc >= CHECK_SHARES);
                    n_ctx   = CTX_BIAS;
                    n_arg   = age;
                    n_state = S_WX;
                end
            end
            S_DSPS: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = r_fast ? r_favg : r_savg;
                req.b     = 64'(r_w);
                req.fb    = FB_Q32;
                n_ret     = S_DRR;
                n_state   = S_WAIT;
            end
            S_DRR: begin
                n_dsps    = r_res_q;
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = r_res_q;
                req.b     = 64'(r_cur);
                req.fb    = FB_DRR;
                n_ret     = S_BAND;
                n_state   = S_WAIT;
            end
            S_BAND: begin
                if (r_res_q > 64'(DRR_LOW) && r_res_q < 64'(DRR_HIGH)) begin
                    n_status = ST_IN_BAND;
                    n_state  = S_PUSH;
                end else begin
                    // integer part of the rate times 3.33 first
                    req.start = 1'b1;
                    req.op    = OP_MUL;
                    req.a     = {20'd0, r_dsps[DW-1:20]};
                    req.b     = 64'(RATE_MUL);
                    n_ret     = S_PDIV1;
                    n_state   = S_WAIT;
                end
            end
            S_PDIV1: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = r_res_r;
                req.b     = 64'(RATE_DIV);
                req.fb    = FB_INT;
                n_ret     = S_PMUL2;
                n_state   = S_WAIT;
            end
            S_PMUL2: begin
                n_pq      = r_res_q;
                n_prem    = r_res_r[6:0];
                req.start = 1'b1;
                req.op    = OP_MUL;
                req.a     = 64'(r_dsps[19:0]);
                req.b     = 64'(RATE_MUL);
                n_ret     = S_PDIV2;
                n_state   = S_WAIT;
            end
            // fraction and remainder, rounded half up
            S_PDIV2: begin
                req.start = 1'b1;
                req.op    = OP_DIV;
                req.a     = numer;
                req.b     = 64'(RATE_DIV) << 20;
                req.fb    = FB_INT;
                n_ret     = S_CLAMP;
                n_state   = S_WAIT;
            end
            S_CLAMP: begin
                n_state = S_PUSH;
                if (opt == '0) begin
                    n_status = ST_BELOW_ONE;
                end else if (opt == 64'(r_cur)) begin
                    n_status = ST_SAME;
                end else if (opt < 64'(r_cur) && r_cnt == 7'd1) begin
                    n_change = r_now;
                    n_status = ST_IDLE_HOLD;
                end else begin
                    n_cnt    = 7'd0;
                    n_change = r_now;
                    n_cur    = DIFF_BITS'(opt);
                    n_status = ST_RETARGET;
                end
            end
            S_PUSH: begin
                if (!r_o_valid || o_result.ready) begin
                    n_o_valid   = 1'b1;
                    n_o_changed = (r_status == ST_RETARGET);
                    n_o_diff    = r_cur;
                    n_o_status  = r_status;
                    n_state     = S_IDLE;
                end
            end
            S_WAIT: begin
                if (rsp.done) begin
                    n_res_q = rsp.q;
                    n_res_r = rsp.r;
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // register write to one of the three registers: update it and restart the session
        if (cfg_we) begin
            case (t_reg'(paddr[4:3]))
                REG_MIN:  n_min  = pwdata[CFG_W-1:0];
                REG_MAX:  n_max  = pwdata[CFG_W-1:0];
                REG_INIT: n_init = pwdata[CFG_W-1:0];
                default:  ;
            endcase
            if (paddr[4:3] != 2'd3) begin
                n_started = 1'b0;
                n_first   = '0;
                n_last    = '0;
                n_change  = '0;
                n_cnt     = 7'd0;
                n_favg    = '0;
                n_savg    = '0;
                n_cur     = clamp_init(n_min, n_max, n_init);
            end
        end
    end

    // control and session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_o_valid <= 1'b0;
            r_min     <= CFG_W'(1);
            r_max     <= '0;
            r_init    <= CFG_W'(1);
            r_started <= 1'b0;
            r_first   <= '0;
            r_last    <= '0;
            r_change  <= '0;
            r_cnt     <= 7'd0;
            r_favg    <= '0;
            r_savg    <= '0;
            r_cur     <= DIFF_BITS'(1);
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_o_valid <= n_o_valid;
            r_min     <= n_min;
            r_max     <= n_max;
            r_init    <= n_init;
            r_started <= n_started;
            r_first   <= n_first;
            r_last    <= n_last;
            r_change  <= n_change;
            r_cnt     <= n_cnt;
            r_favg    <= n_favg;
            r_savg    <= n_savg;
            r_cur     <= n_cur;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_ctx       <= n_ctx;
        r_fast      <= n_fast;
        r_status    <= n_status;
        r_o_changed <= n_o_changed;
        r_o_diff    <= n_o_diff;
        r_o_status  <= n_o_status;
        r_now       <= n_now;
        r_dt        <= n_dt;
        r_arg       <= n_arg;
        r_sdiff     <= n_sdiff;
        r_ndiff     <= n_ndiff;
        r_y         <= n_y;
        r_p         <= n_p;
        r_term      <= n_term;
        r_w         <= n_w;
        r_s         <= n_s;
        r_k         <= n_k;
        r_sqc       <= n_sqc;
        r_dsps      <= n_dsps;
        r_pq        <= n_pq;
        r_prem      <= n_prem;
        r_res_q     <= n_res_q;
        r_res_r     <= n_res_r;
    end

endmodule
